// ===== src/u8san_pkg.sv =====
// Shared types, constants and the byte classifier of the UTF-8 stream sanitizer.
package u8san_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned HOLD_N  = 3;   // lead plus up to two held continuations
  localparam int unsigned SLOT_N  = 4;   // longest sequence that one job carries
  localparam int unsigned NBYTE_W = 3;   // holds 0 .. SLOT_N

  localparam logic [BYTE_W-1:0] NULL_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0] ASCII_TOP  = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
  localparam logic [BYTE_W-1:0] PAT_CONT   = 8'h80;
  localparam logic [BYTE_W-1:0] PAT_LEAD2  = 8'hC0;
  localparam logic [BYTE_W-1:0] PAT_LEAD3  = 8'hE0;
  localparam logic [BYTE_W-1:0] PAT_LEAD4  = 8'hF0;

  typedef enum logic [2:0] {
    CLS_NULL,
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_INVALID
  } byte_class_t;

  // One unit of work for the output side: bytes to send in order, then an
  // optional end-of-string marker.
  typedef struct packed {
    logic [SLOT_N-1:0][BYTE_W-1:0] bytes;
    logic [NBYTE_W-1:0]            nbytes;
    logic                          eos;
  } job_t;

  function automatic byte_class_t u8san_classify(input logic [BYTE_W-1:0] b);
    byte_class_t cls;
    if (b == NULL_BYTE) begin
      cls = CLS_NULL;
    end else if (b < ASCII_TOP) begin
      cls = CLS_ASCII;
    end else if ((b & MASK_CONT) == PAT_CONT) begin
      cls = CLS_CONT;
    end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
      cls = CLS_LEAD2;
    end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
      cls = CLS_LEAD3;
    end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_INVALID;
    end
    return cls;
  endfunction

endpackage

// ===== src/u8san_front.sv =====
// Input side: classifies each byte, tracks the open sequence and builds output jobs.
module u8san_front import u8san_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              end_of_string,
  output logic              push,
  output job_t              job
);

  logic [HOLD_N-1:0][BYTE_W-1:0] held_bytes, held_bytes_next;
  logic [1:0]                    held_count, held_count_next;
  logic [1:0]                    needed_count, needed_count_next;
  logic                          consumed;
  byte_class_t                   cls;

  always_comb begin
    cls               = u8san_classify(in_byte);
    held_bytes_next   = held_bytes;
    held_count_next   = held_count;
    needed_count_next = needed_count;
    consumed          = 1'b0;
    job.bytes         = {in_byte, held_bytes};
    job.nbytes        = '0;
    job.eos           = end_of_string;

    if (needed_count != 2'd0) begin
      if (cls == CLS_CONT) begin
        consumed = 1'b1;
        if (needed_count == 2'd1) begin
          // Sequence complete: held bytes followed by this one.
          job.bytes[held_count] = in_byte;
          job.nbytes            = {1'b0, held_count} + NBYTE_W'(1);
          held_count_next       = 2'd0;
          needed_count_next     = 2'd0;
        end else begin
          held_bytes_next[held_count] = in_byte;
          held_count_next             = held_count + 2'd1;
          needed_count_next           = needed_count - 2'd1;
        end
      end else begin
        // Broken sequence: drop what is held and look at this byte as new.
        held_count_next   = 2'd0;
        needed_count_next = 2'd0;
      end
    end

    if (!consumed) begin
      unique case (cls)
        CLS_ASCII: begin
          job.bytes[0] = in_byte;
          job.nbytes   = NBYTE_W'(1);
        end
        CLS_LEAD2: begin
          held_bytes_next[0] = in_byte;
          held_count_next    = 2'd1;
          needed_count_next  = 2'd1;
        end
        CLS_LEAD3: begin
          held_bytes_next[0] = in_byte;
          held_count_next    = 2'd1;
          needed_count_next  = 2'd2;
        end
        CLS_LEAD4: begin
          held_bytes_next[0] = in_byte;
          held_count_next    = 2'd1;
          needed_count_next  = 2'd3;
        end
        default: begin
        end
      endcase
    end

    if (end_of_string) begin
      held_count_next   = 2'd0;
      needed_count_next = 2'd0;
    end

    push = accept && ((job.nbytes != '0) || end_of_string);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      needed_count <= 2'd0;
    end else if (accept) begin
      held_count   <= held_count_next;
      needed_count <= needed_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= held_bytes_next;
    end
  end

endmodule

// ===== src/u8san_queue.sv =====
// Short job queue that decouples the input side from the output side.
module u8san_queue import u8san_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== src/u8san_back.sv =====
// Output side: unrolls each job into result transfers through an output register.
module u8san_back import u8san_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_empty,
  input  job_t              job,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  logic [NBYTE_W-1:0] idx;
  logic               load;
  logic               is_byte;
  logic               final_one;
  logic [BYTE_W-1:0]  sel_byte;

  always_comb begin
    load      = !job_empty && (!m_tvalid || m_tready);
    is_byte   = (idx < job.nbytes);
    sel_byte  = job.bytes[idx[1:0]];
    final_one = is_byte ? ((idx == job.nbytes - NBYTE_W'(1)) && !job.eos) : 1'b1;
    pop       = load && final_one;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= final_one ? '0 : idx + NBYTE_W'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= is_byte ? sel_byte : NULL_BYTE;
      m_tuser <= {!is_byte, is_byte};
      m_tlast <= final_one;
    end
  end

endmodule

// ===== src/utf8_stream_sanitizer.sv =====
// Top level of the UTF-8 stream sanitizer.
//
// The sanitizer takes one byte per transfer on the slave side, with tlast on
// the last byte of each string, and returns the cleaned stream on the master
// side one byte per transfer. Null bytes are removed, ASCII bytes pass, and a
// 2-, 3- or 4-byte UTF-8 sequence is held until all of its continuation bytes
// have arrived and then sent whole. A broken sequence, a stray continuation
// byte and bytes 0xF8 to 0xFF are dropped; the byte that breaks a sequence is
// examined again as a possible lead. At the end of a string any partial
// sequence is dropped and a marker transfer with no byte (tuser[0] low,
// tuser[1] high) closes the string. tlast on the master side marks the final
// result caused by one input byte. Overlong forms and surrogates are not
// checked. The input side accepts one byte every cycle while the job queue
// has room; each input byte becomes at most one job, and the output side
// sends one result per cycle while m_tready is high, so a byte that
// completes a sequence or ends a string yields up to five results. The
// QUEUE_DEPTH-job queue between the two sides absorbs those bursts; when
// it fills, tready drops until the output side drains a job. The first
// result of a byte passes through the job queue and the output register
// before it is presented on the master side.
module utf8_stream_sanitizer import u8san_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // end_of_string
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] byte_present, [1] string_done
  output logic       m_tlast    // run_last
);

  logic accept;
  logic push;
  logic full;
  logic empty;
  logic pop;
  job_t new_job;
  job_t head_job;

  // The input side only waits on room in the queue.
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  u8san_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (s_tdata),
    .end_of_string (s_tlast),
    .push          (push),
    .job           (new_job)
  );

  u8san_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (new_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head_job)
  );

  u8san_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (empty),
    .job       (head_job),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
